// File: hw/rtl/tdv_pkg.sv
// ---------------------------------------------------------------------------
// tdv_pkg
// Shared types and codes for the type descriptor validator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tdv_pkg;

  // descriptor characters
  localparam logic [7:0] CH_LPAREN = 8'h28;  // (
  localparam logic [7:0] CH_RPAREN = 8'h29;  // )
  localparam logic [7:0] CH_LBRACK = 8'h5B;  // [
  localparam logic [7:0] CH_SEMI   = 8'h3B;  // ;
  localparam logic [7:0] CH_CLASS  = 8'h4C;  // L
  localparam logic [7:0] CH_VOID   = 8'h56;  // V
  localparam logic [7:0] CH_BOOL   = 8'h5A;  // Z
  localparam logic [7:0] CH_BYTE   = 8'h42;  // B
  localparam logic [7:0] CH_CHAR   = 8'h43;  // C
  localparam logic [7:0] CH_DOUBLE = 8'h44;  // D
  localparam logic [7:0] CH_FLOAT  = 8'h46;  // F
  localparam logic [7:0] CH_INT    = 8'h49;  // I
  localparam logic [7:0] CH_LONG   = 8'h4A;  // J
  localparam logic [7:0] CH_SHORT  = 8'h53;  // S

  // parse phase
  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_TYPE  = 2'd1;
  localparam logic [1:0] PH_NAME  = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  // error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_UNKNOWN   = 3'd1;
  localparam logic [2:0] ERR_VOID      = 3'd2;
  localparam logic [2:0] ERR_CLASSNAME = 3'd3;
  localparam logic [2:0] ERR_NORETURN  = 3'd4;
  localparam logic [2:0] ERR_TRAILING  = 3'd5;

  typedef struct packed {
    logic [7:0] desc_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic       valid_res;
    logic [2:0] error_code;
  } result_t;

  typedef struct packed {
    logic [1:0] phase;
    logic       method_form;
    logic       after_close_paren;
    logic       array_pending;
    logic       name_nonempty;
    logic [2:0] first_error;
  } parse_state_t;

  localparam parse_state_t STATE_CLEAR = '{
    phase:             PH_START,
    method_form:       1'b0,
    after_close_paren: 1'b0,
    array_pending:     1'b0,
    name_nonempty:     1'b0,
    first_error:       ERR_NONE
  };

endpackage

`default_nettype wire

// File: hw/rtl/tdv_step.sv
// ---------------------------------------------------------------------------
// tdv_step
// Next-state and result logic for one descriptor character.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tdv_step (
  input  wire tdv_pkg::parse_state_t st,
  input  wire tdv_pkg::item_t        item,
  output tdv_pkg::parse_state_t      st_next,
  output tdv_pkg::result_t           result
);

  tdv_pkg::parse_state_t upd;
  logic                  mf;
  logic [2:0]            err;
  logic [2:0]            end_err;

  always_comb begin
    upd = st;
    mf  = st.method_form;

    if (st.first_error == tdv_pkg::ERR_NONE) begin
      unique case (st.phase)
        tdv_pkg::PH_START, tdv_pkg::PH_TYPE: begin
          if (st.phase == tdv_pkg::PH_START && item.desc_byte == tdv_pkg::CH_LPAREN) begin
            upd.method_form       = 1'b1;
            upd.after_close_paren = 1'b0;
            upd.phase             = tdv_pkg::PH_TYPE;
          end else begin
            // anything but '(' as first char means field form
            if (st.phase == tdv_pkg::PH_START) begin
              mf              = 1'b0;
              upd.method_form = 1'b0;
            end
            case (item.desc_byte)
              tdv_pkg::CH_BOOL, tdv_pkg::CH_BYTE, tdv_pkg::CH_CHAR,
              tdv_pkg::CH_DOUBLE, tdv_pkg::CH_FLOAT, tdv_pkg::CH_INT,
              tdv_pkg::CH_LONG, tdv_pkg::CH_SHORT: begin
                upd.array_pending = 1'b0;
                upd.phase = (mf && !st.after_close_paren) ? tdv_pkg::PH_TYPE
                                                          : tdv_pkg::PH_DONE;
              end
              tdv_pkg::CH_LBRACK: begin
                upd.array_pending = 1'b1;
                upd.phase         = tdv_pkg::PH_TYPE;
              end
              tdv_pkg::CH_CLASS: begin
                upd.name_nonempty = 1'b0;
                upd.phase         = tdv_pkg::PH_NAME;
              end
              tdv_pkg::CH_VOID: begin
                // void only as return type, never as array element
                if (mf && st.after_close_paren && !st.array_pending) begin
                  upd.array_pending = 1'b0;
                  upd.phase         = tdv_pkg::PH_DONE;
                end else begin
                  upd.first_error = tdv_pkg::ERR_VOID;
                end
              end
              tdv_pkg::CH_RPAREN: begin
                if (mf && !st.after_close_paren && !st.array_pending) begin
                  upd.after_close_paren = 1'b1;
                  upd.phase             = tdv_pkg::PH_TYPE;
                end else begin
                  upd.first_error = tdv_pkg::ERR_UNKNOWN;
                end
              end
              default: upd.first_error = tdv_pkg::ERR_UNKNOWN;
            endcase
          end
        end
        tdv_pkg::PH_NAME: begin
          if (item.desc_byte == tdv_pkg::CH_SEMI) begin
            if (st.name_nonempty) begin
              upd.array_pending = 1'b0;
              upd.phase = (st.method_form && !st.after_close_paren) ? tdv_pkg::PH_TYPE
                                                                    : tdv_pkg::PH_DONE;
            end else begin
              upd.first_error = tdv_pkg::ERR_CLASSNAME;
            end
          end else begin
            upd.name_nonempty = 1'b1;
          end
        end
        tdv_pkg::PH_DONE: upd.first_error = tdv_pkg::ERR_TRAILING;
        default:          upd.first_error = tdv_pkg::ERR_TRAILING;
      endcase
    end

    // end-of-descriptor check
    priority if (upd.phase == tdv_pkg::PH_DONE) begin
      end_err = tdv_pkg::ERR_NONE;
    end else if (upd.phase == tdv_pkg::PH_NAME) begin
      end_err = tdv_pkg::ERR_CLASSNAME;
    end else if (upd.method_form) begin
      end_err = tdv_pkg::ERR_NORETURN;
    end else begin
      end_err = tdv_pkg::ERR_UNKNOWN;
    end

    err = (upd.first_error != tdv_pkg::ERR_NONE) ? upd.first_error : end_err;

    result.valid_res  = (err == tdv_pkg::ERR_NONE);
    result.error_code = err;

    st_next = item.last_byte ? tdv_pkg::STATE_CLEAR : upd;
  end

endmodule

`default_nettype wire

// File: hw/rtl/type_descriptor_validator_top.sv
// ---------------------------------------------------------------------------
// type_descriptor_validator_top
// Streaming checker for field and method type descriptors, one char a word.
// ---------------------------------------------------------------------------
//   channel  dir  handshake                    payload
//   item     in   item_valid / item_ready      tdv_pkg::item_t   (char, last flag)
//   result   out  result_valid / result_ready  tdv_pkg::result_t (ok flag, error code)
//
//   one word per cycle unless a last word stalls; each word passes through the input register
//   the verdict is registered from the input register when its last word leaves it
//   a result is produced only for a word that carries the last flag
// while a verdict waits, a last word stalls in the input register; others pass
// reset clears the parse state and both valid flags, no clearing pass
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module type_descriptor_validator_top (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    item_valid,
  output logic                   item_ready,
  input  wire tdv_pkg::item_t    item,
  output logic                   result_valid,
  input  wire                    result_ready,
  output tdv_pkg::result_t       result
);

  tdv_pkg::item_t        in_q;
  logic                  in_valid;
  tdv_pkg::parse_state_t st;
  tdv_pkg::parse_state_t st_next;
  tdv_pkg::result_t      step_res;
  logic                  go;

  // a non-last word never needs the result slot
  assign go = in_valid && (!in_q.last_byte || !result_valid || result_ready);
  assign item_ready = !in_valid || go;

  tdv_step u_step (
    .st      (st),
    .item    (in_q),
    .st_next (st_next),
    .result  (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item_ready) begin
      in_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      in_q <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= tdv_pkg::STATE_CLEAR;
    end else if (go) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (go && in_q.last_byte) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && in_q.last_byte) begin
      result <= step_res;
    end
  end

  // ok flag agrees with the error code
  a_ok_matches_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.valid_res == (result.error_code == tdv_pkg::ERR_NONE)))
    else $error("ok flag disagrees with error code");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.error_code <= tdv_pkg::ERR_TRAILING))
    else $error("error code out of range");

  // last word returns the parser to its start state
  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    (go && in_q.last_byte) |=>
      (st.phase == tdv_pkg::PH_START && st.first_error == tdv_pkg::ERR_NONE))
    else $error("parse state not cleared after last word");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !go |=> $stable(st))
    else $error("parse state moved without a word");

  // a latched error survives until the last word
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    (go && !in_q.last_byte && st.first_error != tdv_pkg::ERR_NONE) |=>
      (st.first_error == $past(st.first_error)))
    else $error("latched error changed");

endmodule

`default_nettype wire

// File: dv/type_descriptor_validator_checker.sv
// ---------------------------------------------------------------------------
// type_descriptor_validator_checker
// Watches both channels of the validator, tracks the descriptor parse on
// every accepted word and compares each verdict with the predicted one.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module type_descriptor_validator_checker (
  input  wire              clk,
  input  wire              rst,
  input  wire              item_valid,
  input  wire              item_ready,
  input  tdv_pkg::item_t   item,
  input  wire              result_valid,
  input  wire              result_ready,
  input  tdv_pkg::result_t result,
  output int               fail_count,
  output int               verdicts_due
);

  tdv_pkg::parse_state_t pst;
  tdv_pkg::result_t      expected_verdicts[$];

  task automatic close_type();
    pst.array_pending = 1'b0;
    pst.phase = (pst.method_form && !pst.after_close_paren) ? tdv_pkg::PH_TYPE
                                                            : tdv_pkg::PH_DONE;
  endtask

  task automatic type_char(input logic [7:0] c);
    case (c)
      tdv_pkg::CH_BOOL, tdv_pkg::CH_BYTE, tdv_pkg::CH_CHAR, tdv_pkg::CH_DOUBLE,
      tdv_pkg::CH_FLOAT, tdv_pkg::CH_INT, tdv_pkg::CH_LONG, tdv_pkg::CH_SHORT: begin
        close_type();
      end
      tdv_pkg::CH_LBRACK: begin
        pst.array_pending = 1'b1;
        pst.phase = tdv_pkg::PH_TYPE;
      end
      tdv_pkg::CH_CLASS: begin
        pst.name_nonempty = 1'b0;
        pst.phase = tdv_pkg::PH_NAME;
      end
      tdv_pkg::CH_VOID: begin
        if (pst.method_form && pst.after_close_paren && !pst.array_pending) begin
          close_type();
        end else begin
          pst.first_error = tdv_pkg::ERR_VOID;
        end
      end
      tdv_pkg::CH_RPAREN: begin
        if (pst.method_form && !pst.after_close_paren && !pst.array_pending) begin
          pst.after_close_paren = 1'b1;
          pst.phase = tdv_pkg::PH_TYPE;
        end else begin
          pst.first_error = tdv_pkg::ERR_UNKNOWN;
        end
      end
      default: begin
        pst.first_error = tdv_pkg::ERR_UNKNOWN;
      end
    endcase
  endtask

  task automatic parse_char(input logic [7:0] c);
    case (pst.phase)
      tdv_pkg::PH_START: begin
        if (c == tdv_pkg::CH_LPAREN) begin
          pst.method_form = 1'b1;
          pst.after_close_paren = 1'b0;
          pst.phase = tdv_pkg::PH_TYPE;
        end else begin
          pst.method_form = 1'b0;
          type_char(c);
        end
      end
      tdv_pkg::PH_TYPE: begin
        type_char(c);
      end
      tdv_pkg::PH_NAME: begin
        if (c == tdv_pkg::CH_SEMI) begin
          if (pst.name_nonempty) begin
            close_type();
          end else begin
            pst.first_error = tdv_pkg::ERR_CLASSNAME;
          end
        end else begin
          pst.name_nonempty = 1'b1;
        end
      end
      default: begin
        pst.first_error = tdv_pkg::ERR_TRAILING;
      end
    endcase
  endtask

  // code for a descriptor that ends with no error latched
  function automatic logic [2:0] end_code();
    if (pst.phase == tdv_pkg::PH_DONE) return tdv_pkg::ERR_NONE;
    if (pst.phase == tdv_pkg::PH_NAME) return tdv_pkg::ERR_CLASSNAME;
    if (pst.method_form) return tdv_pkg::ERR_NORETURN;
    return tdv_pkg::ERR_UNKNOWN;
  endfunction

  always @(posedge clk) begin : watch
    tdv_pkg::result_t want;
    logic [2:0]       code;
    if (rst) begin
      pst = tdv_pkg::STATE_CLEAR;
      expected_verdicts.delete();
      fail_count = 0;
    end else begin
      // a verdict leaving this edge belongs to an earlier word, so pop first
      if (result_valid && result_ready) begin
        if (expected_verdicts.size() == 0) begin
          fail_count++;
          $display("%0t: verdict with none expected: valid_res %0b error_code %0d",
                   $time, result.valid_res, result.error_code);
        end else begin
          want = expected_verdicts.pop_front();
          if (result.valid_res !== want.valid_res) begin
            fail_count++;
            $display("%0t: valid_res expected %0b, actual %0b",
                     $time, want.valid_res, result.valid_res);
          end
          if (result.error_code !== want.error_code) begin
            fail_count++;
            $display("%0t: error_code expected %0d, actual %0d",
                     $time, want.error_code, result.error_code);
          end
        end
      end
      if (item_valid && item_ready) begin
        if (pst.first_error == tdv_pkg::ERR_NONE) parse_char(item.desc_byte);
        if (item.last_byte) begin
          code = pst.first_error;
          if (code == tdv_pkg::ERR_NONE) code = end_code();
          want.valid_res = (code == tdv_pkg::ERR_NONE);
          want.error_code = code;
          expected_verdicts.push_back(want);
          pst = tdv_pkg::STATE_CLEAR;
        end
      end
    end
    verdicts_due = expected_verdicts.size();
  end

endmodule

// File: dv/tb_type_descriptor_validator_top.sv
// ---------------------------------------------------------------------------
// tb_type_descriptor_validator_top
// Feeds the validator a short list of hand-picked descriptors, then random
// field and method descriptors, about half of them corrupted, under
// random idling on both sides and one long receiver hold-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_type_descriptor_validator_top;

  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 4;
  localparam int TOTAL_ITEMS  = 1900;
  localparam int CALM_ITEMS   = 300;
  localparam int LONG_HOLD    = 300;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;

  logic             clk = 1'b0;
  logic             rst;
  logic             item_valid;
  logic             item_ready;
  tdv_pkg::item_t   item;
  logic             result_valid;
  logic             result_ready;
  tdv_pkg::result_t result;

  int         fail_count;
  int         verdicts_due;
  int         items_sent = 0;
  int         idle_cycles = 0;
  int         gap_pct = 0;
  bit         item_taken = 1'b0;
  bit         quiet_tail = 1'b0;
  bit         hold_req = 1'b0;
  logic [7:0] chars[$];

  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  type_descriptor_validator_top uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  type_descriptor_validator_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .fail_count   (fail_count),
    .verdicts_due (verdicts_due)
  );

  // acceptance flag for the sender, plus the no-progress watchdog
  always @(posedge clk) begin
    item_taken <= item_valid && item_ready;
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("type_descriptor_validator_top regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random stall bursts, one long hold-off, none in the tail
  initial begin : receiver
    int stall_pct;
    bit held;
    stall_pct = 10;
    held = 1'b0;
    result_ready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        result_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end else begin
        result_ready <= 1'b1;
        @(negedge clk);
      end
      if ($urandom_range(0, 63) == 0) begin
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 8;
          default: stall_pct = 30;
        endcase
      end
    end
  end

  task automatic send_word(input logic [7:0] c, input logic last);
    tdv_pkg::item_t w;
    w.desc_byte = c;
    w.last_byte = last;
    if (!quiet_tail && $urandom_range(0, 99) < gap_pct) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    item <= w;
    item_valid <= 1'b1;
    do @(negedge clk); while (!item_taken);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], i == s.len() - 1);
  endtask

  task automatic send_chars();
    for (int i = 0; i < chars.size(); i++) send_word(chars[i], i == chars.size() - 1);
  endtask

  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 7))
      0: return tdv_pkg::CH_LPAREN;
      1: return tdv_pkg::CH_RPAREN;
      2: return tdv_pkg::CH_LBRACK;
      3: return tdv_pkg::CH_VOID;
      4: return tdv_pkg::CH_SEMI;
      5: return tdv_pkg::CH_CLASS;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one well-formed type: base, class name or (return only) void
  function automatic void put_type(input bit allow_void);
    int         kind;
    int         dims;
    int         len;
    logic [7:0] c;
    kind = $urandom_range(0, allow_void ? 10 : 9);
    dims = (kind != 10 && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (dims) chars.push_back(tdv_pkg::CH_LBRACK);
    case (kind)
      0: chars.push_back(tdv_pkg::CH_BOOL);
      1: chars.push_back(tdv_pkg::CH_BYTE);
      2: chars.push_back(tdv_pkg::CH_CHAR);
      3: chars.push_back(tdv_pkg::CH_DOUBLE);
      4: chars.push_back(tdv_pkg::CH_FLOAT);
      5: chars.push_back(tdv_pkg::CH_INT);
      6: chars.push_back(tdv_pkg::CH_LONG);
      7: chars.push_back(tdv_pkg::CH_SHORT);
      10: chars.push_back(tdv_pkg::CH_VOID);
      default: begin
        chars.push_back(tdv_pkg::CH_CLASS);
        len = $urandom_range(1, 4);
        repeat (len) begin
          c = 8'($urandom_range(0, 255));
          if (c == tdv_pkg::CH_SEMI) c = tdv_pkg::CH_CLASS;
          chars.push_back(c);
        end
        chars.push_back(tdv_pkg::CH_SEMI);
      end
    endcase
  endfunction

  // about half the descriptors stay valid; the rest get one corruption or are pure noise
  function automatic void make_descriptor();
    int n;
    int pos;
    chars.delete();
    if ($urandom_range(0, 1)) begin
      chars.push_back(tdv_pkg::CH_LPAREN);
      n = $urandom_range(0, 4);
      repeat (n) put_type(1'b0);
      chars.push_back(tdv_pkg::CH_RPAREN);
      put_type(1'b1);
    end else begin
      put_type(1'b0);
    end
    pos = $urandom_range(0, chars.size() - 1);
    case ($urandom_range(0, 11))
      0: chars.push_back(noise_char());
      1: chars.insert(pos, noise_char());
      2: if (chars.size() > 1) chars.delete(pos);
      3: while (chars.size() > pos + 1) void'(chars.pop_back());
      4: chars[pos] = noise_char();
      5: begin
        chars.delete();
        n = $urandom_range(1, 6);
        repeat (n) chars.push_back(noise_char());
      end
      default: ;
    endcase
  endfunction

  initial begin : stimulus
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // hand-picked corner descriptors
    send_text("I");
    send_text("(");
    send_text(")");
    send_text("V");
    send_text("[");
    send_word(8'hFF, 1'b1);
    send_text("L;");
    send_word(tdv_pkg::CH_CLASS, 1'b0);
    send_word(8'h00, 1'b1);
    send_text("ZB");
    send_text("([)");
    send_text("()[V");
    send_text("(D)");
    send_text("()V");

    // long receiver hold-off while words keep coming
    hold_req = 1'b1;
    while (items_sent < TOTAL_ITEMS) begin
      if ($urandom_range(0, 39) == 0) begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 10;
          default: gap_pct = 40;
        endcase
      end
      if (items_sent >= TOTAL_ITEMS - CALM_ITEMS) quiet_tail = 1'b1;
      make_descriptor();
      send_chars();
    end
    item_valid <= 1'b0;

    while (verdicts_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("type_descriptor_validator_top regression: pass");
    end else begin
      $display("type_descriptor_validator_top regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/tdv_pkg.sv
hw/rtl/tdv_step.sv
hw/rtl/type_descriptor_validator_top.sv
dv/type_descriptor_validator_checker.sv
dv/tb_type_descriptor_validator_top.sv
